@@ rtl/core/pfma_pkg.sv @@
`timescale 1ns / 1ps
package pfma_pkg;

    localparam int FIELD_WORDS_DEF = 4;
    localparam int WORD_WIDTH_DEF  = 64;
    localparam int IO_WORDS        = 4;
    localparam int IO_WIDTH        = 64;
    localparam int PADDR_W         = 6;

    // register index of the montgomery constant, prime words sit below it
    localparam logic [2:0] REG_MF = 3'd4;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_MUL    = 3'd2,
        CMD_HALVE  = 3'd3,
        CMD_REDUCE = 3'd4,
        CMD_FULL   = 3'd5
    } t_cmd;

    // travels with each item down the pipeline
    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] top;
    } t_tag;

endpackage

@@ rtl/core/pfma_in_if.sv @@
`timescale 1ns / 1ps
interface pfma_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [63:0] a_w0;
    logic [63:0] a_w1;
    logic [63:0] a_w2;
    logic [63:0] a_w3;
    logic [63:0] b_w0;
    logic [63:0] b_w1;
    logic [63:0] b_w2;
    logic [63:0] b_w3;

    modport source (output valid, cmd, a_w0, a_w1, a_w2, a_w3, b_w0, b_w1, b_w2, b_w3,
                    input ready);
    modport sink (input valid, cmd, a_w0, a_w1, a_w2, a_w3, b_w0, b_w1, b_w2, b_w3,
                  output ready);
endinterface

@@ rtl/core/pfma_out_if.sv @@
`timescale 1ns / 1ps
interface pfma_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_w0;
    logic [63:0] result_w1;
    logic [63:0] result_w2;
    logic [63:0] result_w3;

    modport source (output valid, result_w0, result_w1, result_w2, result_w3, input ready);
    modport sink (input valid, result_w0, result_w1, result_w2, result_w3, output ready);
endinterface

@@ rtl/core/pfma_pre.sv @@
`timescale 1ns / 1ps
module pfma_pre
    import pfma_pkg::*;
#(
    parameter int FIELD_WORDS = FIELD_WORDS_DEF,
    parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  t_cmd                              i_cmd,
    input  logic [FIELD_WORDS*WORD_WIDTH-1:0] i_a,
    input  logic [FIELD_WORDS*WORD_WIDTH-1:0] i_b,
    input  logic [FIELD_WORDS*WORD_WIDTH-1:0] i_prime,
    output logic                              o_valid,
    input  logic                              i_ready,
    output t_tag                              o_tag,
    output logic [FIELD_WORDS*WORD_WIDTH-1:0] o_x,
    output logic [FIELD_WORDS*WORD_WIDTH-1:0] o_y,
    output logic [FIELD_WORDS*WORD_WIDTH-1:0] o_acc
);
    localparam int NW = FIELD_WORDS * WORD_WIDTH;

    logic          r_valid;
    t_tag          r_tag, n_tag;
    logic [NW-1:0] r_x, r_y, r_acc, n_acc;
    logic [NW:0]   sum_ab, sum_a1, dif_ab, dif_ap;
    logic [NW-1:0] dif_pa;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        sum_ab = {1'b0, i_a} + {1'b0, i_b};
        sum_a1 = {1'b0, i_a} + (NW+1)'(1);
        dif_ab = {1'b0, i_a} - {1'b0, i_b} - (NW+1)'(1);
        dif_ap = {1'b0, i_a} - {1'b0, i_prime};
        dif_pa = i_prime - i_a;
        n_tag.cmd = i_cmd;
        n_tag.top = 2'b00;
        n_acc = '0;
        case (i_cmd)
            CMD_ADD: begin
                n_acc = sum_ab[NW-1:0];
                n_tag.top = {1'b0, sum_ab[NW]};
            end
            CMD_REDUCE: begin
                n_acc = sum_a1[NW-1:0];
                n_tag.top = {1'b0, sum_a1[NW]};
            end
            CMD_SUB: begin
                n_acc = dif_ab[NW-1:0];
                n_tag.top = {1'b0, dif_ab[NW]};
            end
            CMD_HALVE: begin
                n_acc = i_a[0] ? dif_pa : i_a;
                n_tag.top = {1'b0, i_a[0]};
            end
            CMD_FULL: begin
                // top flags a < p
                n_acc = dif_ap[NW-1:0];
                n_tag.top = {1'b0, dif_ap[NW]};
            end
            default: begin
                n_acc = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tag <= n_tag;
            r_x   <= i_a;
            r_y   <= i_b;
            r_acc <= n_acc;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
endmodule

@@ rtl/core/pfma_cell.sv @@
`timescale 1ns / 1ps
module pfma_cell
    import pfma_pkg::*;
#(
    parameter int FIELD_WORDS = FIELD_WORDS_DEF,
    parameter int WORD_WIDTH  = WORD_WIDTH_DEF,
    parameter int ROW         = 0,
    parameter int STEP        = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  t_tag                              i_tag,
    input  logic [FIELD_WORDS*WORD_WIDTH-1:0] i_x,
    input  logic [FIELD_WORDS*WORD_WIDTH-1:0] i_y,
    input  logic [FIELD_WORDS*WORD_WIDTH-1:0] i_acc,
    input  logic [WORD_WIDTH-1:0]             i_c,
    input  logic [WORD_WIDTH-1:0]             i_c2,
    input  logic [WORD_WIDTH-1:0]             i_u,
    input  logic [FIELD_WORDS*WORD_WIDTH-1:0] i_prime,
    input  logic [WORD_WIDTH-1:0]             i_mf,
    output logic                              o_valid,
    input  logic                              i_ready,
    output t_tag                              o_tag,
    output logic [FIELD_WORDS*WORD_WIDTH-1:0] o_x,
    output logic [FIELD_WORDS*WORD_WIDTH-1:0] o_y,
    output logic [FIELD_WORDS*WORD_WIDTH-1:0] o_acc,
    output logic [WORD_WIDTH-1:0]             o_c,
    output logic [WORD_WIDTH-1:0]             o_c2,
    output logic [WORD_WIDTH-1:0]             o_u
);
    localparam int NW    = FIELD_WORDS * WORD_WIDTH;
    localparam int WW    = WORD_WIDTH;
    localparam int HL    = WW / 2;
    localparam int HH    = WW - HL;
    localparam bit IS_XY = (STEP < FIELD_WORDS);
    localparam bit IS_U  = (STEP == FIELD_WORDS);
    localparam bit IS_P  = (STEP > FIELD_WORDS) && (STEP <= 2 * FIELD_WORDS);
    localparam int J     = IS_XY ? STEP : (IS_P ? STEP - FIELD_WORDS - 1 : 0);

    logic            r1_valid, r_valid, rdy1, rdy2;
    t_tag            r1_tag, r_tag, n_tag;
    logic [NW-1:0]   r1_x, r1_y, r1_acc, r_x, r_y, r_acc, n_acc;
    logic [WW-1:0]   r1_c, r1_c2, r1_u, r_c, r_c2, r_u, n_c, n_c2, n_u;
    logic [WW-1:0]   ma, mb, ca, cb;
    logic [2*HL-1:0] n_pll, r1_pll;
    logic [WW-1:0]   n_plh, n_phl, r1_plh, r1_phl;
    logic [2*HH-1:0] n_phh, r1_phh;
    logic [2*WW-1:0] mac;
    logic [WW:0]     s1, s2;

    assign rdy2    = !r_valid || i_ready;
    assign rdy1    = !r1_valid || rdy2;
    assign o_ready = rdy1;

    // half-word partial products, registered together with the inputs
    always_comb begin
        ma = IS_XY ? i_x[ROW*WW +: WW] : (IS_U ? i_acc[WW-1:0] : i_u);
        mb = IS_XY ? i_y[J*WW +: WW] : (IS_U ? i_mf : i_prime[J*WW +: WW]);
        n_pll = {{HL{1'b0}}, ma[HL-1:0]} * {{HL{1'b0}}, mb[HL-1:0]};
        n_plh = {{HH{1'b0}}, ma[HL-1:0]} * {{HL{1'b0}}, mb[WW-1:HL]};
        n_phl = {{HL{1'b0}}, ma[WW-1:HL]} * {{HH{1'b0}}, mb[HL-1:0]};
        n_phh = {{HH{1'b0}}, ma[WW-1:HL]} * {{HH{1'b0}}, mb[WW-1:HL]};
    end

    // from the registered products: sum them with the addends, update the word or quotient digit
    always_comb begin
        ca = IS_U ? '0 : r1_acc[J*WW +: WW];
        cb = (IS_U || J == 0) ? '0 : (IS_XY ? r1_c : r1_c2);
        mac = {r1_phh, r1_pll} + ((2*WW)'(r1_plh) << HL) + ((2*WW)'(r1_phl) << HL)
            + (2*WW)'(ca) + (2*WW)'(cb);
        // end of row: drop the low word and fold both carries into the top
        s1 = (WW+1)'(r1_tag.top) + {1'b0, r1_c};
        s2 = {1'b0, s1[WW-1:0]} + {1'b0, r1_c2};
        n_tag = r1_tag;
        n_acc = r1_acc;
        n_c   = r1_c;
        n_c2  = r1_c2;
        n_u   = r1_u;
        if (r1_tag.cmd == CMD_MUL) begin
            if (IS_XY) begin
                n_acc[J*WW +: WW] = mac[WW-1:0];
                n_c = mac[2*WW-1:WW];
            end else if (IS_U) begin
                n_u = mac[WW-1:0];
            end else if (IS_P) begin
                n_acc[J*WW +: WW] = mac[WW-1:0];
                n_c2 = mac[2*WW-1:WW];
            end else begin
                n_acc = {s2[WW-1:0], r1_acc[NW-1:WW]};
                n_tag.top = 2'(s1[WW]) + 2'(s2[WW]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_valid <= i_valid;
            end
            if (rdy2) begin
                r_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy1) begin
            r1_tag <= i_tag;
            r1_x   <= i_x;
            r1_y   <= i_y;
            r1_acc <= i_acc;
            r1_c   <= i_c;
            r1_c2  <= i_c2;
            r1_u   <= i_u;
            r1_pll <= n_pll;
            r1_plh <= n_plh;
            r1_phl <= n_phl;
            r1_phh <= n_phh;
        end
        if (r1_valid && rdy2) begin
            r_tag <= n_tag;
            r_x   <= r1_x;
            r_y   <= r1_y;
            r_acc <= n_acc;
            r_c   <= n_c;
            r_c2  <= n_c2;
            r_u   <= n_u;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
    assign o_c     = r_c;
    assign o_c2    = r_c2;
    assign o_u     = r_u;
endmodule

@@ rtl/core/pfma_post.sv @@
`timescale 1ns / 1ps
module pfma_post
    import pfma_pkg::*;
#(
    parameter int FIELD_WORDS = FIELD_WORDS_DEF,
    parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  t_tag                              i_tag,
    input  logic [FIELD_WORDS*WORD_WIDTH-1:0] i_x,
    input  logic [FIELD_WORDS*WORD_WIDTH-1:0] i_acc,
    input  logic [FIELD_WORDS*WORD_WIDTH-1:0] i_prime,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [FIELD_WORDS*WORD_WIDTH-1:0] o_res
);
    localparam int NW = FIELD_WORDS * WORD_WIDTH;

    logic          r_va, r_vb, rdy_a, rdy_b;
    t_cmd          r_cmd_a;
    logic [NW-1:0] r_a, n_a, r_b, n_b;
    logic [NW:0]   dp;
    logic          gt;
    logic [NW-1:0] sh;

    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;

    // quasi reduce, sub correction, halve and full reduce
    always_comb begin
        dp = {1'b0, i_acc} - {1'b0, i_prime};
        gt = !dp[NW] && (dp[NW-1:0] != '0);
        sh = i_acc >> 1;
        case (i_tag.cmd) inside
            CMD_ADD, CMD_REDUCE, CMD_MUL: begin
                n_a = ((i_tag.top != 2'b00) || gt) ? dp[NW-1:0] : i_acc;
            end
            CMD_SUB: begin
                n_a = i_acc + (i_tag.top[0] ? i_prime : '0) + NW'(1);
            end
            CMD_HALVE: begin
                n_a = i_tag.top[0] ? i_prime - sh : sh;
            end
            CMD_FULL: begin
                n_a = i_tag.top[0] ? i_x : i_acc;
            end
            default: begin
                n_a = '0;
            end
        endcase
    end

    // reduce finishes with a modular decrement
    always_comb begin
        n_b = r_a;
        if (r_cmd_a == CMD_REDUCE) begin
            n_b = r_a - NW'(1) + ((r_a[NW-1:1] == '0) ? i_prime : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy_a) begin
            r_a     <= n_a;
            r_cmd_a <= i_tag.cmd;
        end
        if (r_va && rdy_b) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_vb;
    assign o_res   = r_b;
endmodule

@@ rtl/core/prime_field_modular_alu.sv @@
`timescale 1ns / 1ps
// channel  | dir | payload                          | transfer
// i_in     | in  | cmd, a_w0..a_w3, b_w0..b_w3      | valid && ready
// o_out    | out | result_w0..result_w3             | valid && ready
// apb      | in  | prime_w0..w3, mont_factor @ 8*i  | psel && penable && pwrite
//
// one item per cycle while o_out is not back-pressured
// the montgomery product runs through rows of mac cells, one word multiply per cell but the last
// of each row, split into half-word products that are registered and then summed
// every stage holds one item and moves when its successor is free, so bubbles collapse
// i_rst_n is synchronous; it empties the pipeline and clears the prime and montgomery registers to zero
module prime_field_modular_alu
    import pfma_pkg::*;
#(
    parameter int FIELD_WORDS = FIELD_WORDS_DEF,
    parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pfma_in_if.sink            i_in,
    pfma_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    localparam int NW = FIELD_WORDS * WORD_WIDTH;
    localparam int WW = WORD_WIDTH;
    localparam int SR = 2 * FIELD_WORDS + 2;
    localparam int NC = FIELD_WORDS * SR;

    logic [NW-1:0] r_prime;
    logic [WW-1:0] r_mf;
    logic [2:0]    cfg_idx;
    logic          cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime <= '0;
            r_mf    <= '0;
        end else if (cfg_wr) begin
            for (int i = 0; i < FIELD_WORDS && i < IO_WORDS; i++) begin
                if (cfg_idx == 3'(i)) begin
                    r_prime[i*WW +: WW] <= pwdata[WW-1:0];
                end
            end
            if (cfg_idx == REG_MF) begin
                r_mf <= pwdata[WW-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < FIELD_WORDS && i < IO_WORDS; i++) begin
            if (cfg_idx == 3'(i)) begin
                prdata = IO_WIDTH'(r_prime[i*WW +: WW]);
            end
        end
        if (cfg_idx == REG_MF) begin
            prdata = IO_WIDTH'(r_mf);
        end
    end

    logic [IO_WIDTH-1:0] a_io [IO_WORDS];
    logic [IO_WIDTH-1:0] b_io [IO_WORDS];
    logic [IO_WIDTH-1:0] r_io [IO_WORDS];
    logic [NW-1:0]       op_a, op_b, res;

    assign a_io = '{i_in.a_w0, i_in.a_w1, i_in.a_w2, i_in.a_w3};
    assign b_io = '{i_in.b_w0, i_in.b_w1, i_in.b_w2, i_in.b_w3};

    for (genvar g = 0; g < FIELD_WORDS; g++) begin : g_opw
        if (g < IO_WORDS) begin : g_io
            assign op_a[g*WW +: WW] = a_io[g][WW-1:0];
            assign op_b[g*WW +: WW] = b_io[g][WW-1:0];
        end else begin : g_zero
            assign op_a[g*WW +: WW] = '0;
            assign op_b[g*WW +: WW] = '0;
        end
    end

    for (genvar g = 0; g < IO_WORDS; g++) begin : g_resw
        if (g < FIELD_WORDS) begin : g_io
            assign r_io[g] = IO_WIDTH'(res[g*WW +: WW]);
        end else begin : g_zero
            assign r_io[g] = '0;
        end
    end

    assign o_out.result_w0 = r_io[0];
    assign o_out.result_w1 = r_io[1];
    assign o_out.result_w2 = r_io[2];
    assign o_out.result_w3 = r_io[3];

    logic          ch_valid [NC+1];
    logic          ch_ready [NC+1];
    t_tag          ch_tag   [NC+1];
    logic [NW-1:0] ch_x     [NC+1];
    logic [NW-1:0] ch_y     [NC+1];
    logic [NW-1:0] ch_acc   [NC+1];
    logic [WW-1:0] ch_c     [NC+1];
    logic [WW-1:0] ch_c2    [NC+1];
    logic [WW-1:0] ch_u     [NC+1];

    pfma_pre #(
        .FIELD_WORDS(FIELD_WORDS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_cmd   (t_cmd'(i_in.cmd)),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_prime (r_prime),
        .o_valid (ch_valid[0]),
        .i_ready (ch_ready[0]),
        .o_tag   (ch_tag[0]),
        .o_x     (ch_x[0]),
        .o_y     (ch_y[0]),
        .o_acc   (ch_acc[0])
    );

    // carries and quotient digit start unused, each row's first cell ignores them
    assign ch_c[0]  = '0;
    assign ch_c2[0] = '0;
    assign ch_u[0]  = '0;

    for (genvar r = 0; r < FIELD_WORDS; r++) begin : g_row
        for (genvar s = 0; s < SR; s++) begin : g_step
            pfma_cell #(
                .FIELD_WORDS(FIELD_WORDS),
                .WORD_WIDTH (WORD_WIDTH),
                .ROW        (r),
                .STEP       (s)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (ch_valid[r*SR+s]),
                .o_ready (ch_ready[r*SR+s]),
                .i_tag   (ch_tag[r*SR+s]),
                .i_x     (ch_x[r*SR+s]),
                .i_y     (ch_y[r*SR+s]),
                .i_acc   (ch_acc[r*SR+s]),
                .i_c     (ch_c[r*SR+s]),
                .i_c2    (ch_c2[r*SR+s]),
                .i_u     (ch_u[r*SR+s]),
                .i_prime (r_prime),
                .i_mf    (r_mf),
                .o_valid (ch_valid[r*SR+s+1]),
                .i_ready (ch_ready[r*SR+s+1]),
                .o_tag   (ch_tag[r*SR+s+1]),
                .o_x     (ch_x[r*SR+s+1]),
                .o_y     (ch_y[r*SR+s+1]),
                .o_acc   (ch_acc[r*SR+s+1]),
                .o_c     (ch_c[r*SR+s+1]),
                .o_c2    (ch_c2[r*SR+s+1]),
                .o_u     (ch_u[r*SR+s+1])
            );
        end
    end

    pfma_post #(
        .FIELD_WORDS(FIELD_WORDS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ch_valid[NC]),
        .o_ready (ch_ready[NC]),
        .i_tag   (ch_tag[NC]),
        .i_x     (ch_x[NC]),
        .i_acc   (ch_acc[NC]),
        .i_prime (r_prime),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

`ifndef ASSERT_OFF
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    a_stall_from_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without output back-pressure");

    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (ch_valid[0] && ch_valid[NC]))
        else $error("input stalled with an empty stage");
`endif
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import pfma_pkg::*;

    localparam int NW = 4;
    localparam int LAT = 3 + 2 * NW * (2 * NW + 2);
    localparam int N_RAND = 1000;
    localparam longint LIMIT = 400000;

    typedef logic [255:0] t_fe;

    typedef struct {
        logic [2:0] cmd;
        t_fe        a;
        t_fe        b;
        t_fe        res;
        bit         known;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    pfma_in_if  in_ch();
    pfma_out_if out_ch();

    prime_field_modular_alu dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // field constants as held by the predictor
    t_fe        fp;
    logic [63:0] mfac;

    t_fe  results_due[$];
    bit   failed = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    longint cycles = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        {in_ch.a_w3, in_ch.a_w2, in_ch.a_w1, in_ch.a_w0} = '0;
        {in_ch.b_w3, in_ch.b_w2, in_ch.b_w1, in_ch.b_w0} = '0;
        out_ch.ready = 1'b0;
    end

    function automatic t_fe quasi_reduce(t_fe r, bit carry);
        if (carry || r > fp)
            return r - fp;
        return r;
    endfunction

    function automatic t_fe mod_sub(t_fe x, t_fe y);
        logic [256:0] d;
        d = {1'b0, x} - {1'b0, y} - 257'd1;
        return d[256] ? d[255:0] + fp + 256'd1 : d[255:0] + 256'd1;
    endfunction

    function automatic t_fe mont_mul(t_fe x, t_fe y);
        logic [63:0]  acc [NW];
        logic [63:0]  carry, carry2, u;
        logic [127:0] prod;
        logic [65:0]  sum;
        logic [1:0]   top;
        t_fe          r;
        top = 0;
        for (int j = 0; j < NW; j++) acc[j] = 0;
        for (int i = 0; i < NW; i++) begin
            carry = 0;
            carry2 = 0;
            for (int j = 0; j < NW; j++) begin
                prod = x[64*i +: 64] * y[64*j +: 64] + acc[j] + carry;
                acc[j] = prod[63:0];
                carry = prod[127:64];
            end
            u = acc[0] * mfac;
            for (int j = 0; j < NW; j++) begin
                prod = u * fp[64*j +: 64] + acc[j] + carry2;
                acc[j] = prod[63:0];
                carry2 = prod[127:64];
            end
            for (int j = 1; j < NW; j++) acc[j-1] = acc[j];
            sum = top + carry + carry2;
            acc[NW-1] = sum[63:0];
            top = sum[65:64];
        end
        for (int j = 0; j < NW; j++) r[64*j +: 64] = acc[j];
        if (top != 0 || r > fp)
            r = r - fp;
        return r;
    endfunction

    function automatic t_fe field_result(logic [2:0] cmd, t_fe a, t_fe b);
        logic [256:0] s;
        t_fe t;
        case (cmd)
            CMD_ADD: begin
                s = {1'b0, a} + {1'b0, b};
                return quasi_reduce(s[255:0], s[256]);
            end
            CMD_SUB: return mod_sub(a, b);
            CMD_MUL: return mont_mul(a, b);
            CMD_HALVE: begin
                if (a[0]) begin
                    t = (fp - a) >> 1;
                    return fp - t;
                end
                return a >> 1;
            end
            CMD_REDUCE: begin
                s = {1'b0, a} + 257'd1;
                return mod_sub(quasi_reduce(s[255:0], s[256]), 256'd1);
            end
            CMD_FULL: return (a < fp) ? a : a - fp;
            default: return '0;
        endcase
    endfunction

    task automatic reg_write(int idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(8 * idx);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_field(t_fe p, logic [63:0] m);
        for (int i = 0; i < NW; i++) reg_write(i, p[64*i +: 64]);
        reg_write(REG_MF, m);
        fp = p;
        mfac = m;
    endtask

    // -p^-1 mod 2^64 by newton iteration
    function automatic logic [63:0] neg_inv(logic [63:0] p0);
        logic [63:0] x;
        x = p0;
        for (int i = 0; i < 6; i++) x = x * (64'd2 - p0 * x);
        return -x;
    endfunction

    task automatic send_item(logic [2:0] cmd, t_fe a, t_fe b);
        while (($urandom_range(99) < send_idle_pct)) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        {in_ch.a_w3, in_ch.a_w2, in_ch.a_w1, in_ch.a_w0} <= a;
        {in_ch.b_w3, in_ch.b_w2, in_ch.b_w1, in_ch.b_w0} <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        results_due.push_back(field_result(cmd, a, b));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (LAT + 5) @(posedge i_clk);
    endtask

    function automatic t_fe rand_fe();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom};
    endfunction

    // operand in [1,p] mostly, anything otherwise
    function automatic t_fe rand_operand();
        t_fe v;
        int k;
        k = $urandom_range(9);
        v = rand_fe();
        if (k == 0) return v;
        if (k == 1) return fp;
        if (k == 2) return 256'd1;
        if (k == 3) return fp - 256'($urandom_range(3));
        v = v % fp;
        return (v == 0) ? fp : v;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_fe got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.result_w3, out_ch.result_w2, out_ch.result_w1, out_ch.result_w0};
            if (results_due.size() == 0) begin
                $display("%0t unexpected transfer %h", $time, got);
                failed = 1'b1;
            end else begin
                t_fe want;
                want = results_due.pop_front();
                for (int w = 0; w < NW; w++)
                    if (want[64*w +: 64] !== got[64*w +: 64]) begin
                        $display("%0t result_w%0d expected %h got %h", $time, w,
                                 want[64*w +: 64], got[64*w +: 64]);
                        failed = 1'b1;
                    end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    localparam t_fe P256 =
        256'hffffffff_00000001_00000000_00000000_00000000_ffffffff_ffffffff_ffffffff;
    localparam t_fe PSMALL = 256'd101;
    localparam t_fe PMAX = {256{1'b1}};
    localparam t_fe ALL1 = {256{1'b1}};

    t_row dir_rows[$];

    initial begin
        t_fe primes[3];
        primes[0] = P256;
        primes[1] = PSMALL;
        primes[2] = PMAX;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers are zero after reset: p = 0
        fp = '0;
        mfac = '0;
        dir_rows = '{
            '{CMD_ADD, 256'd3, 256'd4, 256'd7, 1'b1},
            '{CMD_FULL, 256'd9, 256'd0, 256'd9, 1'b1},
            '{3'd6, ALL1, ALL1, 256'd0, 1'b1},
            '{3'd7, 256'd5, 256'd5, 256'd0, 1'b1}
        };
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b);
            if (dir_rows[i].res !== field_result(dir_rows[i].cmd, dir_rows[i].a,
                                                 dir_rows[i].b)) begin
                $display("%0t table row %0d expected %h", $time, i, dir_rows[i].res);
                failed = 1'b1;
            end
        end
        drain();

        load_field(P256, neg_inv(P256[63:0]));
        dir_rows = '{
            '{CMD_ADD, P256, P256, P256, 1'b1},
            '{CMD_ADD, P256 - 1, 256'd2, 256'd1, 1'b1},
            '{CMD_ADD, ALL1, ALL1, 256'd0, 1'b0},
            '{CMD_SUB, 256'd5, 256'd5, P256, 1'b1},
            '{CMD_SUB, 256'd1, 256'd2, P256 - 1, 1'b1},
            '{CMD_SUB, 256'd0, ALL1, 256'd0, 1'b0},
            '{CMD_MUL, ALL1, ALL1, 256'd0, 1'b0},
            '{CMD_MUL, P256, 256'd7, P256, 1'b1},
            '{CMD_MUL, 256'd1, P256 - 1, 256'd0, 1'b0},
            '{CMD_HALVE, 256'd8, 256'd0, 256'd4, 1'b1},
            '{CMD_HALVE, 256'd1, 256'd0, 256'd0, 1'b0},
            '{CMD_HALVE, ALL1, ALL1, 256'd0, 1'b0},
            '{CMD_REDUCE, 256'd0, 256'd0, P256, 1'b1},
            '{CMD_REDUCE, ALL1, 256'd0, 256'd0, 1'b0},
            '{CMD_FULL, P256, 256'd0, 256'd0, 1'b1},
            '{CMD_FULL, 256'd1, 256'd0, 256'd1, 1'b1},
            '{3'd6, P256, 256'd1, 256'd0, 1'b1}
        };
        foreach (dir_rows[i]) begin
            if (dir_rows[i].known && dir_rows[i].res !==
                field_result(dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b)) begin
                $display("%0t table row %0d expected %h", $time, i, dir_rows[i].res);
                failed = 1'b1;
            end
            send_item(dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b);
        end
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 34 : 0;
            for (int f = 0; f < 3; f++) begin
                // random odd modulus for the last field of the last phase
                if (f == 2 && phase == 2) begin
                    t_fe rp;
                    rp = rand_fe() | 256'd1;
                    load_field(rp, neg_inv(rp[63:0]));
                end else begin
                    load_field(primes[f], (f == 1 && phase == 1) ? $urandom :
                               neg_inv(primes[f][63:0]));
                end
                for (int n = 0; n < N_RAND / 9; n++) begin
                    logic [2:0] c;
                    c = ($urandom_range(49) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(5));
                    send_item(c, rand_operand(), rand_operand());
                end
                drain();
            end
        end

        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
